// File: hw/rtl/utx_pkg.sv
package utx_pkg;

	// item function codes
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;
	localparam logic [1:0] FUNC_ACK   = 2'd3;

	// register offsets
	localparam logic [2:0] OFF_STATUS  = 3'd0;
	localparam logic [2:0] OFF_CONTROL = 3'd1;
	localparam logic [2:0] OFF_FRAME   = 3'd2;
	localparam logic [2:0] OFF_BAUD_LO = 3'd4;
	localparam logic [2:0] OFF_BAUD_HI = 3'd5;
	localparam logic [2:0] OFF_DATA    = 3'd6;

	// status bit positions
	localparam int ST_RXC  = 7;
	localparam int ST_TXC  = 6;
	localparam int ST_UDRE = 5;
	localparam int ST_U2X  = 1;
	localparam logic [7:0] ST_WMASK = 8'h03;
	localparam logic [7:0] ST_RESET = 8'h20;

	// control bit positions
	localparam int CT_RXCIE = 7;
	localparam int CT_TXCIE = 6;
	localparam int CT_UDRIE = 5;
	localparam int CT_TXEN  = 3;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] reg_offset;
		logic [7:0] write_data;
		logic       global_int_enable;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       irq_tx_complete;
		logic       irq_data_empty;
		logic       irq_rx_complete;
	} rsp_t;

endpackage

// File: hw/rtl/utx_req_if.sv
interface utx_req_if import utx_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/utx_rsp_if.sv
interface utx_rsp_if import utx_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/uart_tx_register_model_top.sv
// serial transmitter behind a byte register window
// req channel: one item per bus event (register write, register read,
//   clock tick, or acknowledge of the transmit-complete interrupt)
// rsp channel: exactly one result item per request item, in order, carrying
//   read data, the byte that finished shifting out and the interrupt requests
// flow: a request item taken lands in the input register, and its result is
//   then registered in the output register
// throughput: one item per cycle unless rsp.ready stalls; the register state
//   is updated by one pass of short logic between the input register and the
//   result register, so the next item sees the updated state without a bubble
// stall: when the receiver holds rsp.ready low the result stays put and the
//   input register holds its item; req.ready drops once both are full and
//   comes back the cycle the result is taken
// reset: arst_n clears both valid flags and returns the registers to their
//   power-up values (data-empty and shift-empty flags set, everything else zero)
module uart_tx_register_model_top import utx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	utx_req_if.sink   req,
	utx_rsp_if.source rsp
);

	// pipeline registers
	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// block state
	logic [7:0]  status_q, status_n;
	logic [7:0]  control_q, control_n;
	logic [7:0]  frame_q, frame_n;
	logic [15:0] baud_q, baud_n;
	logic [7:0]  last_data_q, last_data_n;
	logic [7:0]  holding_q, holding_n;
	logic [7:0]  shift_q, shift_n;
	logic        shift_empty_q, shift_empty_n;
	logic        holding_full_q, holding_full_n;
	logic [15:0] ticks_q, ticks_n;

	logic [15:0] load_count;
	logic [15:0] ticks_dec;
	logic        advance;
	rsp_t        result;

	// the input stage moves on when the result register is free or being taken
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// reload value: divisor, halved in double speed
	assign load_count = status_q[ST_U2X] ? {1'b0, baud_q[15:1]} : baud_q;
	assign ticks_dec  = ticks_q - 16'd1;

	always_comb begin
		status_n       = status_q;
		control_n      = control_q;
		frame_n        = frame_q;
		baud_n         = baud_q;
		last_data_n    = last_data_q;
		holding_n      = holding_q;
		shift_n        = shift_q;
		shift_empty_n  = shift_empty_q;
		holding_full_n = holding_full_q;
		ticks_n        = ticks_q;
		result         = '0;

		case (req_s1.func)
			FUNC_WRITE: begin
				case (req_s1.reg_offset)
					OFF_STATUS: begin
						// one in TXC clears it, low two bits take the written value
						if (req_s1.write_data[ST_TXC]) begin
							status_n[ST_TXC] = 1'b0;
						end
						status_n = (status_n & ~ST_WMASK) | (req_s1.write_data & ST_WMASK);
					end
					OFF_CONTROL: control_n = req_s1.write_data;
					OFF_FRAME:   frame_n = req_s1.write_data;
					OFF_BAUD_LO: baud_n[7:0] = req_s1.write_data;
					OFF_BAUD_HI: baud_n[15:8] = req_s1.write_data;
					OFF_DATA: begin
						last_data_n = req_s1.write_data;
						if (control_q[CT_TXEN]) begin
							if (ticks_q == 16'd0) begin
								ticks_n = load_count;
							end
							if (shift_empty_q) begin
								shift_n            = req_s1.write_data;
								holding_n          = 8'd0;
								shift_empty_n      = 1'b0;
								holding_full_n     = 1'b0;
								status_n[ST_UDRE]  = 1'b1;
							end else begin
								// a byte already held is overwritten
								holding_n          = req_s1.write_data;
								holding_full_n     = 1'b1;
								status_n[ST_UDRE]  = 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
			FUNC_READ: begin
				case (req_s1.reg_offset)
					OFF_STATUS:  result.read_data = status_q;
					OFF_CONTROL: result.read_data = control_q;
					OFF_FRAME:   result.read_data = frame_q;
					OFF_BAUD_LO: result.read_data = baud_q[7:0];
					OFF_BAUD_HI: result.read_data = baud_q[15:8];
					OFF_DATA: begin
						result.read_data = last_data_q;
						status_n[ST_RXC] = 1'b0;
					end
					default: result.read_data = 8'd0;
				endcase
			end
			FUNC_ACK: status_n[ST_TXC] = 1'b0;
			default: begin
				// clock tick
				if (control_q[CT_TXEN] && ticks_q != 16'd0) begin
					ticks_n = ticks_dec;
					if (ticks_dec == 16'd0) begin
						result.tx_valid = 1'b1;
						result.tx_byte  = shift_q;
						if (holding_full_q) begin
							// holding byte moves up and the countdown reloads
							shift_n           = holding_q;
							holding_n         = 8'd0;
							holding_full_n    = 1'b0;
							shift_empty_n     = 1'b0;
							status_n[ST_UDRE] = 1'b1;
							ticks_n           = load_count;
						end else begin
							holding_n         = 8'd0;
							shift_n           = 8'd0;
							shift_empty_n     = 1'b1;
							status_n[ST_TXC]  = 1'b1;
						end
					end
				end
				// requests use the flags as left by this tick
				if (req_s1.global_int_enable) begin
					result.irq_tx_complete = control_q[CT_TXCIE] && status_n[ST_TXC];
					result.irq_data_empty  = control_q[CT_UDRIE] && status_n[ST_UDRE];
					result.irq_rx_complete = control_q[CT_RXCIE] && status_n[ST_RXC];
				end
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= result;
		end
	end

	// register state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q       <= ST_RESET;
			control_q      <= 8'd0;
			frame_q        <= 8'd0;
			baud_q         <= 16'd0;
			last_data_q    <= 8'd0;
			holding_q      <= 8'd0;
			shift_q        <= 8'd0;
			shift_empty_q  <= 1'b1;
			holding_full_q <= 1'b0;
			ticks_q        <= 16'd0;
		end else if (advance && valid_s1) begin
			status_q       <= status_n;
			control_q      <= control_n;
			frame_q        <= frame_n;
			baud_q         <= baud_n;
			last_data_q    <= last_data_n;
			holding_q      <= holding_n;
			shift_q        <= shift_n;
			shift_empty_q  <= shift_empty_n;
			holding_full_q <= holding_full_n;
			ticks_q        <= ticks_n;
		end
	end

	// a held byte always sits behind a busy shift stage
	a_hold_behind_shift: assert property (@(posedge clk) disable iff (!arst_n)
		holding_full_q |-> !shift_empty_q)
		else $error("holding byte with empty shift stage");

	// data-empty flag mirrors the holding buffer
	a_udre_tracks_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[ST_UDRE] == !holding_full_q)
		else $error("data-empty flag out of step with holding buffer");

	// error flags are never set
	a_err_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[4:2] == 3'd0)
		else $error("status error flags set");

	// only tick items can emit a byte or raise a request
	a_tick_only_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && req_s1.func != FUNC_TICK) |=>
		(!rsp_q.tx_valid && !rsp_q.irq_tx_complete && !rsp_q.irq_data_empty
		&& !rsp_q.irq_rx_complete))
		else $error("transmit or request on a non-tick item");

endmodule
